### rtl/lihsc_pkg.sv
// Shared types and widths for the heading and speed controller.
package lihsc_pkg;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 80;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic [1:0] {
    OP_ATTITUDE  = 2'd0,
    OP_SPEED     = 2'd1,
    OP_REFERENCE = 2'd2,
    OP_TICK      = 2'd3
  } opcode_t;

  // Configuration register indexes; the last one is not backed by a register.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_HEADING     = 3'd0,
    REG_GAIN_TURN_RATE   = 3'd1,
    REG_GAIN_SURGE       = 3'd2,
    REG_GAIN_HEADING_INT = 3'd3,
    REG_GAIN_SURGE_INT   = 3'd4,
    REG_SMOOTHING_WEIGHT = 3'd5,
    REG_STEP_PERIOD      = 3'd6,
    REG_UNUSED           = 3'd7
  } reg_idx_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [3:0] {
    M_NONE,
    M_TWOPI_TC,
    M_W_X,
    M_W1_S,
    M_PER_E0,
    M_PER_E1,
    M_GH_Y,
    M_GR_R,
    M_GHI_I0,
    M_GS_S,
    M_GSI_I1,
    M_PWM0,
    M_PWM1
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // State update performed in this cycle.
  typedef enum logic [3:0] {
    W_NONE,
    W_TURN,
    W_UNWRAP,
    W_SMOOTH,
    W_REF,
    W_INT0,
    W_INT1,
    W_DIFF,
    W_FORCE,
    W_PWM0,
    W_OUT
  } wr_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    wr_sel_t  wr_sel;
  } dp_cmd_t;

endpackage

### rtl/lqr_integral_heading_speed_controller_unit.sv
// Top level of the LQR heading and speed controller with integral action.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready  | tuser: opcode; tdata: sensor/reference
//  out_    | out | out_tvalid/tready | tdata: pwm_first, pwm_second
//  cfg_    | in  | cfg_wr_en         | cfg_addr index, cfg_wdata value
//
// An input beat is taken only while the sequencer is idle; the item then runs
// through its attitude, speed, reference or tick steps on one shared 25x34
// multiplier, and the sequencer returns to idle after the last step.
// A tick that finds the output register still full holds in its last step.
// rst_n is synchronous and active low; it restores the default gains and
// clears the unwrap, smoothing, reference and integrator state.
module lqr_integral_heading_speed_controller_unit import lihsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [14:0] yaw_angle, [30:15] yaw_rate, [46:31] surge_speed,
  // [62:47] target_yaw, [78:63] target_speed, [79] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] pwm_first, [31:16] pwm_second
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  // Step sequencer: one state per datapath step, one output beat per tick.
  lihsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (opcode_t'(in_tuser)),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Arithmetic, state and config registers.
  lihsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

### rtl/lihsc_ctrl.sv
// Sequencer for the controller: steps the datapath through each item kind.
module lihsc_ctrl import lihsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  opcode_t in_opcode,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ATT0, ST_ATT1, ST_ATT2,
    ST_SPD0, ST_SPD1, ST_SPD2, ST_SPD3,
    ST_REF,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
    ST_T6, ST_T7, ST_T8, ST_T9, ST_T10, ST_T11
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   emit_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign emit_ok    = !out_valid_r || out_tready;

  // Drop the beat once taken; raise it as a tick leaves its last step.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if ((state_r == ST_T11) && emit_ok) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    cmd = '{load_in: 1'b0, mul_sel: M_NONE, acc_op: ACC_HOLD, wr_sel: W_NONE};
    unique case (state_r)
      ST_IDLE: cmd.load_in = in_tvalid;
      ST_ATT0: cmd.wr_sel  = W_TURN;
      ST_ATT1: cmd.mul_sel = M_TWOPI_TC;
      ST_ATT2: cmd.wr_sel  = W_UNWRAP;
      ST_SPD0: cmd.mul_sel = M_W_X;
      ST_SPD1: begin
        cmd.mul_sel = M_W1_S;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_SPD2: cmd.acc_op = ACC_ADD;
      ST_SPD3: cmd.wr_sel = W_SMOOTH;
      ST_REF:  cmd.wr_sel = W_REF;
      ST_T0:   cmd.mul_sel = M_PER_E0;
      ST_T1: begin
        cmd.mul_sel = M_PER_E1;
        cmd.wr_sel  = W_INT0;
      end
      ST_T2: begin
        cmd.mul_sel = M_GH_Y;
        cmd.wr_sel  = W_INT1;
      end
      ST_T3: begin
        cmd.mul_sel = M_GR_R;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_T4: begin
        cmd.mul_sel = M_GHI_I0;
        cmd.acc_op  = ACC_ADD;
      end
      ST_T5: begin
        cmd.mul_sel = M_GS_S;
        cmd.acc_op  = ACC_ADD;
      end
      ST_T6: begin
        cmd.mul_sel = M_GSI_I1;
        cmd.acc_op  = ACC_LOAD;
        cmd.wr_sel  = W_DIFF;
      end
      ST_T7:  cmd.acc_op  = ACC_ADD;
      ST_T8:  cmd.wr_sel  = W_FORCE;
      ST_T9:  cmd.mul_sel = M_PWM0;
      ST_T10: begin
        cmd.mul_sel = M_PWM1;
        cmd.wr_sel  = W_PWM0;
      end
      ST_T11: if (emit_ok) begin
        cmd.wr_sel = W_OUT;
      end
      default: cmd.load_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: if (in_tvalid) begin
          unique case (in_opcode)
            OP_ATTITUDE:  state_r <= ST_ATT0;
            OP_SPEED:     state_r <= ST_SPD0;
            OP_REFERENCE: state_r <= ST_REF;
            OP_TICK:      state_r <= ST_T0;
            default:      state_r <= ST_IDLE;
          endcase
        end
        ST_ATT0: state_r <= ST_ATT1;
        ST_ATT1: state_r <= ST_ATT2;
        ST_ATT2: state_r <= ST_IDLE;
        ST_SPD0: state_r <= ST_SPD1;
        ST_SPD1: state_r <= ST_SPD2;
        ST_SPD2: state_r <= ST_SPD3;
        ST_SPD3: state_r <= ST_IDLE;
        ST_REF:  state_r <= ST_IDLE;
        ST_T0:   state_r <= ST_T1;
        ST_T1:   state_r <= ST_T2;
        ST_T2:   state_r <= ST_T3;
        ST_T3:   state_r <= ST_T4;
        ST_T4:   state_r <= ST_T5;
        ST_T5:   state_r <= ST_T6;
        ST_T6:   state_r <= ST_T7;
        ST_T7:   state_r <= ST_T8;
        ST_T8:   state_r <= ST_T9;
        ST_T9:   state_r <= ST_T10;
        ST_T10:  state_r <= ST_T11;
        ST_T11: if (emit_ok) begin
          // Hold here until the output register is free.
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/lihsc_dp.sv
// Datapath: config registers, controller state, shared multiplier and accumulator.
module lihsc_dp import lihsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic signed [23:0] GH_RST  = 24'sd509538;
  localparam logic signed [23:0] GR_RST  = 24'sd465736;
  localparam logic signed [23:0] GS_RST  = 24'sd363493;
  localparam logic signed [23:0] GHI_RST = -24'sd84668;
  localparam logic signed [23:0] GSI_RST = -24'sd72804;
  localparam logic [15:0]        W_RST   = 16'd655;
  localparam logic [15:0]        PER_RST = 16'd3277;

  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [24:0] TWO_PI_Q16 = 25'sd411775;
  localparam logic signed [24:0] SLOPE_POS  = 25'sd432826;
  localparam logic signed [24:0] SLOPE_NEG  = 25'sd561683;
  localparam logic signed [63:0] OFFSET_POS = 64'sd300719865856;  // 4588621 * 2^16
  localparam logic signed [63:0] OFFSET_NEG = 64'sd394861281280;  // 6025105 * 2^16
  localparam logic signed [63:0] S32_MAX    = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN    = -64'sd2147483648;
  localparam logic signed [63:0] S16_MAX    = 64'sd32767;
  localparam logic signed [63:0] S16_MIN    = -64'sd32768;
  localparam logic signed [63:0] TRUNC_BIAS = 64'sd4294967295;
  localparam logic signed [15:0] TC_MAX     = 16'sd32767;
  localparam logic signed [15:0] TC_MIN     = -16'sd32768;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return c[31:0];
  endfunction

  // Two-piece PWM fit, truncated toward zero, clamped to 16 bits.
  function automatic logic signed [15:0] pwm_fit(input logic signed [58:0] p,
                                                 input logic neg);
    logic signed [63:0] v;
    logic signed [63:0] q;
    logic signed [63:0] c;
    v = neg ? (64'(p) - OFFSET_NEG) : (64'(p) + OFFSET_POS);
    q = (v < 0) ? ((v + TRUNC_BIAS) >>> 32) : (v >>> 32);
    c = (q > S16_MAX) ? S16_MAX : ((q < S16_MIN) ? S16_MIN : q);
    return c[15:0];
  endfunction

  // Configuration.
  logic signed [23:0] gh_r, gr_r, gs_r, ghi_r, gsi_r;
  logic [15:0]        weight_r, period_r;

  // Latched input beat.
  logic signed [14:0] in_yaw_r;
  logic signed [15:0] in_rate_r, in_speed_r, in_tyaw_r, in_tspeed_r;

  // Controller state.
  logic signed [15:0] last_raw_r, turn_r, rate_r, ref0_r, ref1_r;
  logic signed [31:0] unwrap_r, smooth_r, int0_r, int1_r;

  // Working registers.
  logic signed [58:0] prod_r;
  logic signed [63:0] acc_r, diffr_r;
  logic signed [31:0] u0_r, u1_r;
  logic signed [15:0] pwm0_r, out_first_r, out_second_r;

  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [33:0] err0, err1;
  logic signed [15:0] raw16;
  logic signed [16:0] yaw_diff;
  logic signed [15:0] turn_nxt;
  logic signed [63:0] prod_ext, sum0, sum1;

  assign out_tdata = {out_second_r, out_first_r};

  assign err0     = 34'($signed({ref0_r, 4'b0000})) - 34'(unwrap_r);
  assign err1     = 34'($signed({ref1_r, 4'b0000})) - 34'(smooth_r);
  assign raw16    = 16'(in_yaw_r);
  assign yaw_diff = 17'(raw16) - 17'(last_raw_r);
  assign prod_ext = 64'(prod_r);
  assign sum0     = -(diffr_r + acc_r);
  assign sum1     = diffr_r - acc_r;

  always_comb begin
    turn_nxt = turn_r;
    if (yaw_diff >= PI_Q12) begin
      if (turn_r != TC_MAX) turn_nxt = turn_r + 16'sd1;
    end else if (yaw_diff <= -PI_Q12) begin
      if (turn_r != TC_MIN) turn_nxt = turn_r - 16'sd1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      M_TWOPI_TC: begin
        mul_a = TWO_PI_Q16;
        mul_b = 34'(turn_r);
      end
      M_W_X: begin
        mul_a = $signed({9'b0, weight_r});
        mul_b = 34'($signed({in_speed_r, 4'b0000}));
      end
      M_W1_S: begin
        mul_a = $signed({8'b0, 17'd65536 - {1'b0, weight_r}});
        mul_b = 34'(smooth_r);
      end
      M_PER_E0: begin
        mul_a = $signed({9'b0, period_r});
        mul_b = err0;
      end
      M_PER_E1: begin
        mul_a = $signed({9'b0, period_r});
        mul_b = err1;
      end
      M_GH_Y: begin
        mul_a = 25'(gh_r);
        mul_b = 34'(unwrap_r);
      end
      M_GR_R: begin
        mul_a = 25'(gr_r);
        mul_b = 34'($signed({rate_r, 4'b0000}));
      end
      M_GHI_I0: begin
        mul_a = 25'(ghi_r);
        mul_b = 34'(int0_r);
      end
      M_GS_S: begin
        mul_a = 25'(gs_r);
        mul_b = 34'(smooth_r);
      end
      M_GSI_I1: begin
        mul_a = 25'(gsi_r);
        mul_b = 34'(int1_r);
      end
      M_PWM0: begin
        mul_a = u0_r[31] ? SLOPE_NEG : SLOPE_POS;
        mul_b = 34'(u0_r);
      end
      M_PWM1: begin
        mul_a = u1_r[31] ? SLOPE_NEG : SLOPE_POS;
        mul_b = 34'(u1_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Config writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gh_r     <= GH_RST;
      gr_r     <= GR_RST;
      gs_r     <= GS_RST;
      ghi_r    <= GHI_RST;
      gsi_r    <= GSI_RST;
      weight_r <= W_RST;
      period_r <= PER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GAIN_HEADING:     gh_r     <= $signed(cfg_wdata);
        REG_GAIN_TURN_RATE:   gr_r     <= $signed(cfg_wdata);
        REG_GAIN_SURGE:       gs_r     <= $signed(cfg_wdata);
        REG_GAIN_HEADING_INT: ghi_r    <= $signed(cfg_wdata);
        REG_GAIN_SURGE_INT:   gsi_r    <= $signed(cfg_wdata);
        REG_SMOOTHING_WEIGHT: weight_r <= cfg_wdata[15:0];
        REG_STEP_PERIOD:      period_r <= cfg_wdata[15:0];
        default:              gh_r     <= gh_r;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_yaw_r    <= $signed(in_tdata[14:0]);
      in_rate_r   <= $signed(in_tdata[30:15]);
      in_speed_r  <= $signed(in_tdata[46:31]);
      in_tyaw_r   <= $signed(in_tdata[62:47]);
      in_tspeed_r <= $signed(in_tdata[78:63]);
    end
    if (cmd.mul_sel != M_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      default:  acc_r <= acc_r;
    endcase
    unique case (cmd.wr_sel)
      W_DIFF: diffr_r <= acc_r;
      W_FORCE: begin
        u0_r <= sat32((sum0 + 64'sd2048) >>> 12);
        u1_r <= sat32((sum1 + 64'sd2048) >>> 12);
      end
      W_PWM0: pwm0_r <= pwm_fit(prod_r, u0_r[31]);
      W_OUT: begin
        out_first_r  <= pwm0_r;
        out_second_r <= pwm_fit(prod_r, u1_r[31]);
      end
      default: pwm0_r <= pwm0_r;
    endcase
  end

  // Controller state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      turn_r     <= '0;
      rate_r     <= '0;
      ref0_r     <= '0;
      ref1_r     <= '0;
      unwrap_r   <= '0;
      smooth_r   <= '0;
      int0_r     <= '0;
      int1_r     <= '0;
    end else begin
      unique case (cmd.wr_sel)
        W_TURN: begin
          turn_r     <= turn_nxt;
          last_raw_r <= raw16;
          rate_r     <= in_rate_r;
        end
        W_UNWRAP: unwrap_r <= sat32(64'($signed({last_raw_r, 4'b0000})) - prod_ext);
        W_SMOOTH: smooth_r <= sat32((acc_r + 64'sd32768) >>> 16);
        W_REF: begin
          ref0_r <= in_tyaw_r;
          ref1_r <= in_tspeed_r;
        end
        W_INT0: int0_r <= sat32(64'(int0_r) + ((prod_ext + 64'sd32768) >>> 16));
        W_INT1: int1_r <= sat32(64'(int1_r) + ((prod_ext + 64'sd32768) >>> 16));
        default: turn_r <= turn_r;
      endcase
    end
  end

endmodule
